// File: rtl/core/linear_probe_hash_table_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the hash table core.
// ---------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_MACROS_SVH
`define LINEAR_PROBE_HASH_TABLE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define LPHT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/lpht_pkg.sv
// ---------------------------------------------------------------------------
// lpht_pkg
// Types, sizes and codes for the linear probing hash table.
// TABLE_SLOTS is a power of two; the home slot is the hash reduced to it.
// ---------------------------------------------------------------------------
package lpht_pkg;

    localparam int TABLE_SLOTS = 262144;
    localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);
    localparam int ROWS_BITS   = 24;
    localparam int COLS_BITS   = 24;
    localparam int KEY_BITS    = ROWS_BITS + COLS_BITS;
    localparam int VALUE_BITS  = 18;
    localparam int COUNT_BITS  = 18;
    localparam int HASH_SHIFT  = 14;
    localparam int SUM_BITS    = 32;
    localparam int HASH_BITS   = SUM_BITS - HASH_SHIFT;
    localparam int WORD_BITS   = 1 + KEY_BITS + VALUE_BITS;

    localparam logic [SUM_BITS-1:0] HASH_MUL_ROWS    = 32'h4321_2347;
    localparam logic [SUM_BITS-1:0] HASH_MUL_COLUMNS = 32'h5364_3478;

    typedef logic [SLOT_BITS-1:0]  t_slot;
    typedef logic [KEY_BITS-1:0]   t_key;
    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [WORD_BITS-1:0]  t_word;

    localparam t_slot  SLOT_LAST = t_slot'(TABLE_SLOTS - 1);
    localparam t_count COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_LOOKUP = 2'd1,
        ACT_CLEAR  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        STATUS_INSERTED  = 3'd0,
        STATUS_FOUND     = 3'd1,
        STATUS_DUPLICATE = 3'd2,
        STATUS_FULL      = 3'd3,
        STATUS_NOT_FOUND = 3'd4,
        STATUS_CLEARED   = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_CLEAR
    } t_state;

    typedef struct packed {
        logic  wr_en;
        t_slot addr;
        t_word wr_data;
    } t_ram_req;

endpackage

// File: rtl/core/lpht_slot_ram.sv
// ---------------------------------------------------------------------------
// lpht_slot_ram
// Single-port slot store: valid, key and value per slot, registered read.
// ---------------------------------------------------------------------------
module lpht_slot_ram
    import lpht_pkg::*;
(
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_word    o_rd_data
);

    t_word r_mem [TABLE_SLOTS];
    t_word r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wr_data;
        end
        r_rd_data <= r_mem[i_req.addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/core/lpht_hash.sv
// ---------------------------------------------------------------------------
// lpht_hash
// Home slot hash: registered products, then wrapped sum, shift and reduce.
// ---------------------------------------------------------------------------
module lpht_hash
    import lpht_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_load,
    input  logic [ROWS_BITS-1:0] i_key_rows,
    input  logic [COLS_BITS-1:0] i_key_columns,
    output t_slot                o_home
);

    logic [SUM_BITS-1:0]  r_prod_rows;
    logic [SUM_BITS-1:0]  r_prod_columns;
    logic [SUM_BITS-1:0]  sum;
    logic [HASH_BITS-1:0] hash;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_prod_rows    <= SUM_BITS'({{(SUM_BITS-ROWS_BITS){1'b0}}, i_key_rows}
                                        * HASH_MUL_ROWS);
            r_prod_columns <= SUM_BITS'({{(SUM_BITS-COLS_BITS){1'b0}}, i_key_columns}
                                        * HASH_MUL_COLUMNS);
        end
    end

    assign sum    = r_prod_rows + r_prod_columns;
    assign hash   = sum[SUM_BITS-1:HASH_SHIFT];
    assign o_home = t_slot'({{SLOT_BITS{1'b0}}, hash});

endmodule

// File: rtl/core/linear_probe_hash_table.sv
// ---------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressing hash table with linear probing over one slot memory.
//
//   channel   handshake               payload
//   command   start / busy            i_action, i_key_rows, i_key_columns,
//                                     i_entry_index
//   result    o_result_valid strobe   o_status, o_found_index, o_probe_count
//
// Insert and lookup: S_HASH registers the home slot, then S_PROBE passes occupied
// slots until a free slot or a key match, or until the run wraps back to the home
// slot; one probe a cycle. Clear: one slot written per cycle over the whole table.
// Unused action: reported as not found without leaving S_IDLE. After reset, busy
// stays high while the memory is swept clear.
// Results are shown for one cycle only; the receiver cannot stall.
// ---------------------------------------------------------------------------
`include "linear_probe_hash_table_macros.svh"

module linear_probe_hash_table
    import lpht_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_action,
    input  logic [ROWS_BITS-1:0]  i_key_rows,
    input  logic [COLS_BITS-1:0]  i_key_columns,
    input  logic [VALUE_BITS-1:0] i_entry_index,
    output logic                  o_result_valid,
    output logic [2:0]            o_status,
    output logic [VALUE_BITS-1:0] o_found_index,
    output logic [COUNT_BITS-1:0] o_probe_count
);

    t_state   r_state, n_state;
    t_action  r_action;
    t_key     r_key;
    t_value   r_value;
    t_slot    r_home, n_home;
    t_slot    r_slot, n_slot;
    t_count   r_passed, n_passed;
    t_slot    r_sweep, n_sweep;
    logic     r_res_valid, n_res_valid;
    t_status  r_status, n_status;
    t_value   r_found, n_found;
    t_count   r_count, n_count;

    logic     accept;
    t_slot    home;
    t_ram_req ram_req;
    t_word    rd_word;
    logic     slot_used;
    t_key     slot_key;
    t_value   slot_value;
    logic     key_match;
    t_slot    slot_next;
    logic     wrap;
    t_count   passed_inc;

    assign accept = start && !busy;

    lpht_hash u_hash (
        .i_clk         (i_clk),
        .i_load        (accept),
        .i_key_rows    (i_key_rows),
        .i_key_columns (i_key_columns),
        .o_home        (home)
    );

    lpht_slot_ram u_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_word)
    );

    assign slot_used  = rd_word[WORD_BITS-1];
    assign slot_key   = rd_word[VALUE_BITS +: KEY_BITS];
    assign slot_value = rd_word[VALUE_BITS-1:0];
    assign key_match  = slot_key == r_key;
    assign slot_next  = (r_slot == SLOT_LAST) ? '0 : r_slot + 1'b1;
    assign wrap       = slot_next == r_home;
    assign passed_inc = (r_passed == COUNT_MAX) ? r_passed : r_passed + 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT: begin
                if (r_sweep == SLOT_LAST) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    case (t_action'(i_action))
                        ACT_INSERT, ACT_LOOKUP: n_state = S_HASH;
                        ACT_CLEAR:              n_state = S_CLEAR;
                        default:                n_state = S_IDLE;
                    endcase
                end
            end
            S_HASH: begin
                n_state = S_PROBE;
            end
            S_PROBE: begin
                if (!slot_used || key_match || wrap) begin
                    n_state = S_IDLE;
                end
            end
            S_CLEAR: begin
                if (r_sweep == SLOT_LAST) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_home        = r_home;
        n_slot        = r_slot;
        n_passed      = r_passed;
        n_sweep       = r_sweep;
        n_res_valid   = 1'b0;
        n_status      = r_status;
        n_found       = '0;
        n_count       = '0;
        ram_req.wr_en   = 1'b0;
        ram_req.addr    = r_slot;
        ram_req.wr_data = '0;
        case (r_state)
            S_INIT: begin
                ram_req.wr_en = 1'b1;
                ram_req.addr  = r_sweep;
                n_sweep       = r_sweep + 1'b1;
            end
            S_IDLE: begin
                n_sweep = '0;
                if (accept) begin
                    case (t_action'(i_action))
                        ACT_INSERT, ACT_LOOKUP: begin
                        end
                        ACT_CLEAR: begin
                        end
                        default: begin
                            n_res_valid = 1'b1;
                            n_status    = STATUS_NOT_FOUND;
                        end
                    endcase
                end
            end
            S_HASH: begin
                ram_req.addr = home;
                n_home       = home;
                n_slot       = home;
                n_passed     = '0;
            end
            S_PROBE: begin
                ram_req.addr = slot_next;
                if (r_action == ACT_INSERT) begin
                    if (!slot_used) begin
                        ram_req.wr_en   = 1'b1;
                        ram_req.addr    = r_slot;
                        ram_req.wr_data = {1'b1, r_key, r_value};
                        n_res_valid     = 1'b1;
                        n_status        = STATUS_INSERTED;
                        n_count         = r_passed;
                    end else if (key_match) begin
                        n_res_valid = 1'b1;
                        n_status    = STATUS_DUPLICATE;
                    end else if (wrap) begin
                        n_res_valid = 1'b1;
                        n_status    = STATUS_FULL;
                    end
                end else begin
                    if (!slot_used) begin
                        n_res_valid = 1'b1;
                        n_status    = STATUS_NOT_FOUND;
                    end else if (key_match) begin
                        n_res_valid = 1'b1;
                        n_status    = STATUS_FOUND;
                        n_found     = slot_value;
                        n_count     = r_passed;
                    end else if (wrap) begin
                        n_res_valid = 1'b1;
                        n_status    = STATUS_NOT_FOUND;
                    end
                end
                n_slot   = slot_next;
                n_passed = passed_inc;
            end
            S_CLEAR: begin
                ram_req.wr_en = 1'b1;
                ram_req.addr  = r_sweep;
                n_sweep       = r_sweep + 1'b1;
                if (r_sweep == SLOT_LAST) begin
                    n_res_valid = 1'b1;
                    n_status    = STATUS_CLEARED;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_sweep     <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sweep     <= n_sweep;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= t_action'(i_action);
            r_key    <= {i_key_columns, i_key_rows};
            r_value  <= i_entry_index;
        end
        r_home   <= n_home;
        r_slot   <= n_slot;
        r_passed <= n_passed;
        r_status <= n_status;
        r_found  <= n_found;
        r_count  <= n_count;
    end

    assign busy           = r_state != S_IDLE;
    assign o_result_valid = r_res_valid;
    assign o_status       = r_status;
    assign o_found_index  = r_found;
    assign o_probe_count  = r_count;

    `LPHT_ASSERT_NOW(a_result_when_idle, i_clk, i_rst_n, o_result_valid, !busy, "result strobe while busy")
    `LPHT_ASSERT_NEXT(a_probe_starts, i_clk, i_rst_n, accept && (i_action == ACT_INSERT || i_action == ACT_LOOKUP), r_state == S_HASH, "probe did not start")
    `LPHT_ASSERT_NOW(a_first_probe_home, i_clk, i_rst_n, r_state == S_PROBE && r_passed == '0, r_slot == r_home, "first probe away from home slot")
    `LPHT_ASSERT_NOW(a_index_only_found, i_clk, i_rst_n, o_result_valid && o_found_index != '0, o_status == STATUS_FOUND, "index given without a match")

endmodule
